[src/rat_pkg.sv]
// ----------------------------------------------------------------------------
// rat_pkg
// Shared types and codes of the resource admission table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rat_pkg;

  localparam int FIELD_W   = 32;
  localparam int ID_W      = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STOP  = 1'b1;

  localparam logic [1:0] ST_ADMITTED = 2'd0;
  localparam logic [1:0] ST_REJECTED = 2'd1;
  localparam logic [1:0] ST_RELEASED = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_RAM_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISK_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CPU_LIMIT  = 2'd2;

  typedef struct packed {
    logic add;
    logic sub;
  } lane_ctl_t;

endpackage

`default_nettype wire

[src/rat_if.sv]
// ----------------------------------------------------------------------------
// rat_in_if / rat_out_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rat_in_if;
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic [rat_pkg::ID_W-1:0]     app_id;
  logic [rat_pkg::FIELD_W-1:0]  req_ram;
  logic [rat_pkg::FIELD_W-1:0]  req_disk;
  logic [rat_pkg::FIELD_W-1:0]  req_cpu;

  modport source (output valid, command, app_id, req_ram, req_disk, req_cpu,
                  input ready);
  modport sink   (input valid, command, app_id, req_ram, req_disk, req_cpu,
                  output ready);
endinterface

interface rat_out_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic                         forward;
  logic [rat_pkg::FIELD_W-1:0]  used_ram;
  logic [rat_pkg::FIELD_W-1:0]  used_disk;
  logic [rat_pkg::FIELD_W-1:0]  used_cpu;

  modport source (output valid, status, forward, used_ram, used_disk, used_cpu,
                  input ready);
  modport sink   (input valid, status, forward, used_ram, used_disk, used_cpu,
                  output ready);
endinterface

`default_nettype wire

[src/rat_lane.sv]
// ----------------------------------------------------------------------------
// rat_lane
// One resource: running total, capacity check and add/release update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rat_lane #(
  parameter int UNIT_WIDTH = 32
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire rat_pkg::lane_ctl_t ctl,
  input  wire  [UNIT_WIDTH-1:0]   limit,
  input  wire  [UNIT_WIDTH-1:0]   req,
  input  wire  [UNIT_WIDTH-1:0]   amount,
  output logic                    fits,
  output logic [UNIT_WIDTH-1:0]   total
);

  logic [UNIT_WIDTH-1:0] total_r;
  logic [UNIT_WIDTH-1:0] total_nxt;
  logic [UNIT_WIDTH:0]   sum;

  // sum carries one extra bit so an overflow counts as exceeding the limit
  assign sum  = {1'b0, total_r} + {1'b0, req};
  assign fits = (sum <= {1'b0, limit});

  always_comb begin
    total_nxt = total_r;
    if (ctl.add) begin
      total_nxt = sum[UNIT_WIDTH-1:0];
    end else if (ctl.sub) begin
      total_nxt = (amount > total_r) ? '0 : total_r - amount;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else begin
      total_r <= total_nxt;
    end
  end

  assign total = total_r;

endmodule

`default_nettype wire

[src/resource_admission_table.sv]
// ----------------------------------------------------------------------------
// resource_admission_table
// Admission control of ram, disk and cpu amounts per application.
// ----------------------------------------------------------------------------
// Requests arrive on in_ch: a start asks for three amounts for an app, a
// stop releases what the app holds. Each request gives one result on out_ch
// with a status, a forward flag and the three totals after the request.
// The user writes limits on cfg_we/cfg_index/cfg_data while idle, unchecked.
//
// The per-app amounts and valid flag live in one synchronous memory. A
// request first issues the memory read in its transfer cycle; in S_LOOK the
// entry is then checked and written back and the result register loaded,
// once that register is free. A new request is not taken before the last
// one has left S_LOOK, as the memory port does a read, then a write.
//
// After reset a clearing pass writes every entry invalid, one per cycle,
// with in_ch.ready low. If the receiver stalls, a new request is still
// taken while a result waits; that request then holds in its check state
// until the result register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module resource_admission_table #(
  parameter int APP_SLOTS  = 256,
  parameter int UNIT_WIDTH = 32
) (
  input  wire                               clk,
  input  wire                               rst_n,
  rat_in_if.sink                            in_ch,
  rat_out_if.source                         out_ch,
  input  wire                               cfg_we,
  input  wire  [rat_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [rat_pkg::FIELD_W-1:0]       cfg_data
);

  localparam int IDX_W = $clog2(APP_SLOTS);
  localparam int ENT_W = 3 * UNIT_WIDTH + 1;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_LOOK  = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [IDX_W-1:0]      clr_cnt_r;

  logic [UNIT_WIDTH-1:0] ram_limit_r, disk_limit_r, cpu_limit_r;

  logic                  cmd_r;
  logic                  in_table_r;
  logic [IDX_W-1:0]      idx_r;
  logic [UNIT_WIDTH-1:0] req_ram_r, req_disk_r, req_cpu_r;

  logic [ENT_W-1:0]      mem [APP_SLOTS];
  logic [ENT_W-1:0]      ent_rd_r;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [ENT_W-1:0]      mem_wdata;

  logic                  out_valid_r;
  logic [1:0]            status_r;
  logic                  forward_r;

  logic                  in_xfer;
  logic                  commit;
  logic                  ent_valid;
  logic [UNIT_WIDTH-1:0] ent_ram, ent_disk, ent_cpu;
  logic                  fit_ram, fit_disk, fit_cpu;
  logic                  admit, hit;
  logic [UNIT_WIDTH-1:0] tot_ram, tot_disk, tot_cpu;
  rat_pkg::lane_ctl_t    lane_ctl;

  logic [63:0]           cfg_wide, rr_wide, rd_wide, rc_wide;
  logic [63:0]           tr_wide, td_wide, tc_wide;
  logic [16:0]           id_wide;
  logic [IDX_W-1:0]      in_idx;

  // width adaption between the 32-bit fields and the unit width
  assign cfg_wide = 64'(cfg_data);
  assign rr_wide  = 64'(in_ch.req_ram);
  assign rd_wide  = 64'(in_ch.req_disk);
  assign rc_wide  = 64'(in_ch.req_cpu);
  assign id_wide  = 17'(in_ch.app_id);
  assign in_idx   = id_wide[IDX_W-1:0];

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign commit      = (state_r == S_LOOK) && (!out_valid_r || out_ch.ready);

  // state machine
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_cnt_r == IDX_W'(APP_SLOTS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_xfer) state_nxt = S_LOOK;
      end
      S_LOOK: begin
        if (commit) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // limit registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_limit_r  <= '0;
      disk_limit_r <= '0;
      cpu_limit_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rat_pkg::CFG_RAM_LIMIT:  ram_limit_r  <= cfg_wide[UNIT_WIDTH-1:0];
        rat_pkg::CFG_DISK_LIMIT: disk_limit_r <= cfg_wide[UNIT_WIDTH-1:0];
        rat_pkg::CFG_CPU_LIMIT:  cpu_limit_r  <= cfg_wide[UNIT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r      <= in_ch.command;
      in_table_r <= (id_wide < 17'(APP_SLOTS));
      idx_r      <= in_idx;
      req_ram_r  <= rr_wide[UNIT_WIDTH-1:0];
      req_disk_r <= rd_wide[UNIT_WIDTH-1:0];
      req_cpu_r  <= rc_wide[UNIT_WIDTH-1:0];
    end
  end

  // entry memory: {valid, ram, disk, cpu}
  assign {ent_valid, ent_ram, ent_disk, ent_cpu} = ent_rd_r;

  assign admit = in_table_r && fit_ram && fit_disk && fit_cpu;
  assign hit   = in_table_r && ent_valid;

  assign lane_ctl.add = commit && (cmd_r == rat_pkg::CMD_START) && admit;
  assign lane_ctl.sub = commit && (cmd_r == rat_pkg::CMD_STOP) && hit;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = {1'b0, ent_ram, ent_disk, ent_cpu};
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = '0;
    end else if (lane_ctl.add) begin
      mem_we    = 1'b1;
      mem_wdata = {1'b1, req_ram_r, req_disk_r, req_cpu_r};
    end else if (lane_ctl.sub) begin
      mem_we    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (in_xfer) ent_rd_r <= mem[in_idx];
  end

  rat_lane #(.UNIT_WIDTH(UNIT_WIDTH)) u_lane_ram (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (lane_ctl),
    .limit  (ram_limit_r),
    .req    (req_ram_r),
    .amount (ent_ram),
    .fits   (fit_ram),
    .total  (tot_ram)
  );

  rat_lane #(.UNIT_WIDTH(UNIT_WIDTH)) u_lane_disk (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (lane_ctl),
    .limit  (disk_limit_r),
    .req    (req_disk_r),
    .amount (ent_disk),
    .fits   (fit_disk),
    .total  (tot_disk)
  );

  rat_lane #(.UNIT_WIDTH(UNIT_WIDTH)) u_lane_cpu (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (lane_ctl),
    .limit  (cpu_limit_r),
    .req    (req_cpu_r),
    .amount (ent_cpu),
    .fits   (fit_cpu),
    .total  (tot_cpu)
  );

  // result register, totals are read from the lanes after the update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      if (cmd_r == rat_pkg::CMD_START) begin
        status_r  <= admit ? rat_pkg::ST_ADMITTED : rat_pkg::ST_REJECTED;
        forward_r <= admit;
      end else begin
        status_r  <= hit ? rat_pkg::ST_RELEASED : rat_pkg::ST_NOTFOUND;
        forward_r <= hit;
      end
    end
  end

  assign tr_wide = 64'(tot_ram);
  assign td_wide = 64'(tot_disk);
  assign tc_wide = 64'(tot_cpu);

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = status_r;
  assign out_ch.forward   = forward_r;
  assign out_ch.used_ram  = tr_wide[rat_pkg::FIELD_W-1:0];
  assign out_ch.used_disk = td_wide[rat_pkg::FIELD_W-1:0];
  assign out_ch.used_cpu  = tc_wide[rat_pkg::FIELD_W-1:0];

endmodule

`default_nettype wire

[src/rat_checker.sv]
// ----------------------------------------------------------------------------
// rat_checker
// Port-level assertions for the resource admission table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rat_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       in_valid,
  input wire       in_ready,
  input wire       out_valid,
  input wire       out_ready,
  input wire [1:0] out_status,
  input wire       out_forward
);

  // forward flag follows the status code
  a_forward: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_forward == ((out_status == rat_pkg::ST_ADMITTED) ||
                                   (out_status == rat_pkg::ST_RELEASED))))
    else $error("forward flag does not match status");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_status)))
    else $error("stalled result changed");

  // one request at a time: busy right after a transfer
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while previous one in flight");

  // no result directly out of reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind resource_admission_table rat_checker u_rat_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_status  (out_ch.status),
  .out_forward (out_ch.forward)
);

`default_nettype wire

[bench/resource_admission_table_tb.sv]
// ----------------------------------------------------------------------------
// resource_admission_table_tb
// Self-checking bench for the ram/disk/cpu admission table.
// ----------------------------------------------------------------------------
// A directed table walks the corner cases: zero and full-scale limits, carry
// out of a sum, repeated start, stop of an unknown app and a limit lowered
// under its total. Random requests follow over several limit settings.
// Every result is checked field by field against an in-bench model of the
// totals and per-app entries, with random gaps on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module resource_admission_table_tb;

  localparam int SLOTS        = 256;
  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 64;
  localparam int RANDOM_ITEMS = 1700;
  localparam int PHASES       = 12;
  localparam logic [rat_pkg::FIELD_W-1:0] UNIT_MAX = '1;

  typedef struct packed {
    logic                        command;
    logic [rat_pkg::ID_W-1:0]    app_id;
    logic [rat_pkg::FIELD_W-1:0] req_ram;
    logic [rat_pkg::FIELD_W-1:0] req_disk;
    logic [rat_pkg::FIELD_W-1:0] req_cpu;
  } req_t;

  typedef struct packed {
    logic [1:0]                  status;
    logic                        forward;
    logic [rat_pkg::FIELD_W-1:0] used_ram;
    logic [rat_pkg::FIELD_W-1:0] used_disk;
    logic [rat_pkg::FIELD_W-1:0] used_cpu;
  } verdict_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                     kind;
    logic [rat_pkg::CFG_IDX_W-1:0] idx;
    logic [rat_pkg::FIELD_W-1:0]   data;
    req_t                          req;
    bit                            typed;
    verdict_t                      verdict;
  } row_t;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [rat_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rat_pkg::FIELD_W-1:0]   cfg_data;

  rat_in_if  in_if ();
  rat_out_if out_if ();

  resource_admission_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // model state
  logic [rat_pkg::FIELD_W-1:0] lim_ram, lim_disk, lim_cpu;
  logic [rat_pkg::FIELD_W-1:0] held_ram, held_disk, held_cpu;
  bit                          slot_used [SLOTS];
  logic [rat_pkg::FIELD_W-1:0] slot_ram  [SLOTS];
  logic [rat_pkg::FIELD_W-1:0] slot_disk [SLOTS];
  logic [rat_pkg::FIELD_W-1:0] slot_cpu  [SLOTS];

  verdict_t pending_verdicts [$];
  row_t     directed [$];

  int mismatches;
  int n_admit, n_reject, n_release, n_notfound, n_limit_sets;
  int idle_mode;
  bit hold_req;
  int stall_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic bit fits(logic [rat_pkg::FIELD_W-1:0] total,
                              logic [rat_pkg::FIELD_W-1:0] amount,
                              logic [rat_pkg::FIELD_W-1:0] limit);
    logic [rat_pkg::FIELD_W:0] sum;
    sum = {1'b0, total} + {1'b0, amount};
    return sum <= {1'b0, limit};
  endfunction

  function automatic logic [rat_pkg::FIELD_W-1:0] release_amount(
      logic [rat_pkg::FIELD_W-1:0] total, logic [rat_pkg::FIELD_W-1:0] amount);
    return (amount > total) ? '0 : total - amount;
  endfunction

  function automatic verdict_t admit_step(req_t r);
    verdict_t v;
    v = '0;
    if (r.command == rat_pkg::CMD_START) begin
      if (fits(held_ram, r.req_ram, lim_ram) && fits(held_disk, r.req_disk, lim_disk) &&
          fits(held_cpu, r.req_cpu, lim_cpu)) begin
        slot_used[r.app_id] = 1'b1;
        slot_ram[r.app_id]  = r.req_ram;
        slot_disk[r.app_id] = r.req_disk;
        slot_cpu[r.app_id]  = r.req_cpu;
        held_ram  = held_ram + r.req_ram;
        held_disk = held_disk + r.req_disk;
        held_cpu  = held_cpu + r.req_cpu;
        v.status  = rat_pkg::ST_ADMITTED;
        v.forward = 1'b1;
      end else begin
        v.status = rat_pkg::ST_REJECTED;
      end
    end else if (slot_used[r.app_id]) begin
      held_ram  = release_amount(held_ram, slot_ram[r.app_id]);
      held_disk = release_amount(held_disk, slot_disk[r.app_id]);
      held_cpu  = release_amount(held_cpu, slot_cpu[r.app_id]);
      slot_used[r.app_id] = 1'b0;
      v.status  = rat_pkg::ST_RELEASED;
      v.forward = 1'b1;
    end else begin
      v.status = rat_pkg::ST_NOTFOUND;
    end
    v.used_ram  = held_ram;
    v.used_disk = held_disk;
    v.used_cpu  = held_cpu;
    return v;
  endfunction

  function automatic void report_field(string name, logic [rat_pkg::FIELD_W-1:0] want,
                                       logic [rat_pkg::FIELD_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // directed table rows
  function automatic row_t req_row(logic cmd, int id, logic [rat_pkg::FIELD_W-1:0] r,
                                   logic [rat_pkg::FIELD_W-1:0] d,
                                   logic [rat_pkg::FIELD_W-1:0] c);
    row_t row;
    row.kind    = ROW_REQ;
    row.idx     = rat_pkg::CFG_RAM_LIMIT;
    row.data    = '0;
    row.req     = {cmd, rat_pkg::ID_W'(id), r, d, c};
    row.typed   = 1'b0;
    row.verdict = '0;
    return row;
  endfunction

  function automatic row_t typed_row(logic cmd, int id, logic [rat_pkg::FIELD_W-1:0] r,
                                     logic [rat_pkg::FIELD_W-1:0] d,
                                     logic [rat_pkg::FIELD_W-1:0] c,
                                     logic [1:0] st, logic fw,
                                     logic [rat_pkg::FIELD_W-1:0] ur,
                                     logic [rat_pkg::FIELD_W-1:0] ud,
                                     logic [rat_pkg::FIELD_W-1:0] uc);
    row_t row;
    row         = req_row(cmd, id, r, d, c);
    row.typed   = 1'b1;
    row.verdict = {st, fw, ur, ud, uc};
    return row;
  endfunction

  function automatic row_t cfg_row(logic [rat_pkg::CFG_IDX_W-1:0] idx,
                                   logic [rat_pkg::FIELD_W-1:0] data);
    row_t row;
    row      = req_row(rat_pkg::CMD_START, 0, '0, '0, '0);
    row.kind = ROW_CFG;
    row.idx  = idx;
    row.data = data;
    return row;
  endfunction

  // random stimulus
  function automatic logic [rat_pkg::FIELD_W-1:0] pick_amount(
      logic [rat_pkg::FIELD_W-1:0] total, logic [rat_pkg::FIELD_W-1:0] limit);
    logic [rat_pkg::FIELD_W-1:0] room;
    room = (limit >= total) ? limit - total : '0;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return $urandom;
      2: return room;
      3: return room + 1'b1;
      4: return UNIT_MAX;
      default: return $urandom_range(0, room >> 2);
    endcase
  endfunction

  function automatic int pick_recorded();
    int base;
    base = $urandom_range(0, SLOTS - 1);
    for (int k = 0; k < SLOTS; k++) begin
      if (slot_used[rat_pkg::ID_W'((base + k) % SLOTS)]) return (base + k) % SLOTS;
    end
    return -1;
  endfunction

  function automatic req_t make_req();
    req_t r;
    int   pick;
    int   hit;
    r.req_ram  = $urandom;
    r.req_disk = $urandom;
    r.req_cpu  = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      r.command  = rat_pkg::CMD_START;
      r.app_id   = ($urandom_range(0, 1) != 0) ? rat_pkg::ID_W'($urandom_range(0, 15))
                                               : rat_pkg::ID_W'($urandom_range(0, SLOTS - 1));
      r.req_ram  = pick_amount(held_ram, lim_ram);
      r.req_disk = pick_amount(held_disk, lim_disk);
      r.req_cpu  = pick_amount(held_cpu, lim_cpu);
    end else begin
      r.command = rat_pkg::CMD_STOP;
      hit = pick_recorded();
      if (pick < 95 && hit >= 0) r.app_id = rat_pkg::ID_W'(hit);
      else r.app_id = rat_pkg::ID_W'($urandom_range(0, SLOTS - 1));
    end
    return r;
  endfunction

  function automatic logic [rat_pkg::FIELD_W-1:0] pick_limit();
    case ($urandom_range(0, 4))
      0: return UNIT_MAX;
      1: return $urandom;
      2: return $urandom_range(0, 1000);
      3: return '0;
      default: return $urandom_range(32'h0010_0000, 32'h0100_0000);
    endcase
  endfunction

  task automatic wait_idle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limit(logic [rat_pkg::CFG_IDX_W-1:0] idx,
                           logic [rat_pkg::FIELD_W-1:0] data);
    wait_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      rat_pkg::CFG_RAM_LIMIT:  lim_ram  = data;
      rat_pkg::CFG_DISK_LIMIT: lim_disk = data;
      rat_pkg::CFG_CPU_LIMIT:  lim_cpu  = data;
      default: ;
    endcase
    n_limit_sets++;
  endtask

  task automatic set_all_limits(logic [rat_pkg::FIELD_W-1:0] r,
                                logic [rat_pkg::FIELD_W-1:0] d,
                                logic [rat_pkg::FIELD_W-1:0] c);
    set_limit(rat_pkg::CFG_RAM_LIMIT, r);
    set_limit(rat_pkg::CFG_DISK_LIMIT, d);
    set_limit(rat_pkg::CFG_CPU_LIMIT, c);
  endtask

  task automatic send_req(req_t r, bit typed, verdict_t typed_v);
    int       gap;
    verdict_t v;
    gap = (idle_mode == 1 || idle_mode == 2) ? $urandom_range(0, 8) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.command  <= r.command;
    in_if.app_id   <= r.app_id;
    in_if.req_ram  <= r.req_ram;
    in_if.req_disk <= r.req_disk;
    in_if.req_cpu  <= r.req_cpu;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    v = admit_step(r);
    pending_verdicts.push_back(typed ? typed_v : v);
    case (v.status)
      rat_pkg::ST_ADMITTED: n_admit++;
      rat_pkg::ST_REJECTED: n_reject++;
      rat_pkg::ST_RELEASED: n_release++;
      default:              n_notfound++;
    endcase
  endtask

  // result side
  initial begin
    int       gap;
    verdict_t want;
    out_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_req) begin
        gap      = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        gap = (idle_mode == 1 || idle_mode == 3) ? $urandom_range(0, 8) : 0;
      end
      @(negedge clk);
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (!out_if.valid) @(posedge clk);
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d", $time,
                 out_if.status);
        mismatches++;
      end else begin
        want = pending_verdicts.pop_front();
        report_field("status", want.status, out_if.status);
        report_field("forward", want.forward, out_if.forward);
        report_field("used_ram", want.used_ram, out_if.used_ram);
        report_field("used_disk", want.used_disk, out_if.used_disk);
        report_field("used_cpu", want.used_cpu, out_if.used_cpu);
      end
    end
  end

  // watchdog on transfers
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    int per_phase;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_if.valid    = 1'b0;
    in_if.command  = rat_pkg::CMD_START;
    in_if.app_id   = '0;
    in_if.req_ram  = '0;
    in_if.req_disk = '0;
    in_if.req_cpu  = '0;
    lim_ram = '0; lim_disk = '0; lim_cpu = '0;
    held_ram = '0; held_disk = '0; held_cpu = '0;
    for (int k = 0; k < SLOTS; k++) begin
      slot_used[rat_pkg::ID_W'(k)] = 1'b0;
      slot_ram[rat_pkg::ID_W'(k)]  = '0;
      slot_disk[rat_pkg::ID_W'(k)] = '0;
      slot_cpu[rat_pkg::ID_W'(k)]  = '0;
    end
    mismatches = 0;
    n_admit = 0; n_reject = 0; n_release = 0; n_notfound = 0; n_limit_sets = 0;
    idle_mode    = 1;
    hold_req     = 1'b0;
    stall_cycles = 0;

    // limits are zero out of reset
    directed.push_back(typed_row(rat_pkg::CMD_START, 0, 0, 0, 0,
                                 rat_pkg::ST_ADMITTED, 1'b1, 0, 0, 0));
    directed.push_back(typed_row(rat_pkg::CMD_START, 1, 1, 0, 0,
                                 rat_pkg::ST_REJECTED, 1'b0, 0, 0, 0));
    directed.push_back(typed_row(rat_pkg::CMD_STOP, 7, 0, 0, 0,
                                 rat_pkg::ST_NOTFOUND, 1'b0, 0, 0, 0));
    directed.push_back(typed_row(rat_pkg::CMD_STOP, 0, UNIT_MAX, UNIT_MAX, UNIT_MAX,
                                 rat_pkg::ST_RELEASED, 1'b1, 0, 0, 0));
    directed.push_back(cfg_row(rat_pkg::CFG_RAM_LIMIT, UNIT_MAX));
    directed.push_back(cfg_row(rat_pkg::CFG_DISK_LIMIT, UNIT_MAX));
    directed.push_back(cfg_row(rat_pkg::CFG_CPU_LIMIT, UNIT_MAX));
    directed.push_back(typed_row(rat_pkg::CMD_START, 255, UNIT_MAX, UNIT_MAX, UNIT_MAX,
                                 rat_pkg::ST_ADMITTED, 1'b1, UNIT_MAX, UNIT_MAX, UNIT_MAX));
    // carry out of the cpu sum
    directed.push_back(typed_row(rat_pkg::CMD_START, 1, 0, 0, 1, rat_pkg::ST_REJECTED, 1'b0,
                                 UNIT_MAX, UNIT_MAX, UNIT_MAX));
    directed.push_back(typed_row(rat_pkg::CMD_START, 128, 0, 0, 0, rat_pkg::ST_ADMITTED,
                                 1'b1, UNIT_MAX, UNIT_MAX, UNIT_MAX));
    directed.push_back(typed_row(rat_pkg::CMD_STOP, 255, 0, 0, 0,
                                 rat_pkg::ST_RELEASED, 1'b1, 0, 0, 0));
    // repeated start keeps the earlier amounts in the totals
    directed.push_back(req_row(rat_pkg::CMD_START, 42, 32'h5555_5555, 32'hAAAA_AAAA,
                               32'h0000_FFFF));
    directed.push_back(req_row(rat_pkg::CMD_START, 42, 32'hAAAA_AAAA, 32'h5555_5555,
                               32'hFFFF_0000));
    directed.push_back(req_row(rat_pkg::CMD_STOP, 42, 0, 0, 0));
    directed.push_back(req_row(rat_pkg::CMD_STOP, 42, 0, 0, 0));
    directed.push_back(req_row(rat_pkg::CMD_STOP, 128, 0, 0, 0));
    // limit lowered under the running total
    directed.push_back(cfg_row(rat_pkg::CFG_RAM_LIMIT, 32'd100));
    directed.push_back(req_row(rat_pkg::CMD_START, 3, 1, 0, 0));
    directed.push_back(req_row(rat_pkg::CMD_START, 3, 0, 1, 1));
    directed.push_back(cfg_row(rat_pkg::CFG_RAM_LIMIT, 32'h8000_0000));
    directed.push_back(req_row(rat_pkg::CMD_START, 200, 32'h8000_0000 - 32'h5555_5555,
                               5, 5));
    directed.push_back(req_row(rat_pkg::CMD_START, 201, 1, 0, 0));
    directed.push_back(req_row(rat_pkg::CMD_STOP, 3, 0, 0, 0));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) set_limit(directed[i].idx, directed[i].data);
      else send_req(directed[i].req, directed[i].typed, directed[i].verdict);
    end

    per_phase = RANDOM_ITEMS / PHASES;
    for (int ph = 0; ph < PHASES; ph++) begin
      idle_mode = ph % 4;
      if (ph == 0) set_all_limits(UNIT_MAX, UNIT_MAX, UNIT_MAX);
      else if (ph == 1) set_all_limits('0, '0, '0);
      else set_all_limits(pick_limit(), pick_limit(), pick_limit());
      for (int i = 0; i < per_phase; i++) begin
        if (idle_mode == 3 && i == per_phase / 2) begin
          // long receiver stall while requests keep coming
          hold_req = 1'b1;
          repeat (12) send_req(make_req(), 1'b0, '0);
        end
        if (ph == 6 && i == per_phase / 2) wait_idle();
        send_req(make_req(), 1'b0, '0);
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    $display("run covered %0d admitted, %0d rejected, %0d released, %0d not found",
             n_admit, n_reject, n_release, n_notfound);
    $display("limits written %0d times, zero and full scale included", n_limit_sets);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
